// File: design/kbct_pkg.sv
// Shared types and constants for the contact bucket.
package kbct_pkg;
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_TOUCH   = 2'd1;
  localparam logic [1:0] OP_CLOSEST = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_GLOBAL   = 3'd2;
  localparam logic [2:0] ST_SUBNET   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_NORESULT = 3'd6;

  localparam logic [31:0] SUBNET_MASK        = 32'hFFFFFF00;
  localparam logic [3:0]  SUBNET_LIMIT_RESET = 4'd2;
  localparam int          MAX_OUT            = 10;

  localparam logic [0:0] REG_SUBNET_LIMIT = 1'b0;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] ip;
    logic [15:0] port;
    logic [2:0]  ctype;
    logic        verified;
    logic [7:0]  version;
  } contact_t;
endpackage

// File: design/kbct_cmp.sv
// Shared 128-bit XOR distance compare used by the selection scan.
module kbct_cmp (
  input  logic [127:0] target,
  input  logic [127:0] cand_id,
  input  logic [127:0] best_dist,
  output logic [127:0] cand_dist,
  output logic         less
);
  assign cand_dist = cand_id ^ target;
  assign less      = cand_dist < best_dist;
endmodule

// File: design/kbucket_contact_table_core.sv
// Top level of the contact bucket: sequencer, entry store and stream ports.
// Add: the input transfer is followed by the scan, decide and output states before a valid result.
// Touch: as Add, and when the entry is found a shift state then rotates it up to the top slot.
// Closest: each result takes a selection scan through the shared compare and a pick, up to 10 results.
// One item at a time: in_tready returns the cycle after the last result transfers.
// Reset (synchronous, rst_n low) empties the bucket and sets subnet_limit to 2.
module kbucket_contact_table_core #(
  parameter int BUCKET_SIZE = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, id_high, id_low, ip_addr, udp_port, contact_type, ip_verified,
  // proto_version, is_lan, global_ok, max_type, max_required, zero pad
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, res_id_high, res_id_low, res_ip, res_port, zero pad
  output logic [183:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int IW = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
  localparam int CW = $clog2(BUCKET_SIZE + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_PICK = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  kbct_pkg::contact_t mem_r [BUCKET_SIZE];
  logic [BUCKET_SIZE-1:0] taken_r;

  logic [2:0]   state_r;
  logic [CW-1:0] count_r;
  logic [3:0]   limit_r;
  logic [CW-1:0] idx_r;
  logic [1:0]   op_r;
  kbct_pkg::contact_t in_c_r;
  logic         lan_r, gok_r;
  logic [2:0]   maxt_r;
  logic [3:0]   want_r, given_r;
  logic         found_r;
  logic [IW-1:0] fidx_r, best_r;
  logic         have_r;
  logic [127:0] bdist_r;
  logic [CW-1:0] same_r;
  logic [CW-1:0] ecnt_r;
  kbct_pkg::contact_t hold_r;
  logic         ovalid_r, olast_r;
  logic [2:0]   ostat_r;
  kbct_pkg::contact_t ores_r;

  logic [IW-1:0] idx;
  kbct_pkg::contact_t cur;
  logic [127:0] cdist;
  logic         cless;
  logic         acc, out_acc, cfg_wr;
  logic         ov_set;

  assign idx = idx_r[IW-1:0];
  assign cur = mem_r[idx];
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == kbct_pkg::REG_SUBNET_LIMIT) ? {28'd0, limit_r} : 32'd0;

  kbct_cmp u_cmp (
    .target   ({in_c_r.id_high, in_c_r.id_low}),
    .cand_id  ({cur.id_high, cur.id_low}),
    .best_dist(bdist_r),
    .cand_dist(cdist),
    .less     (cless)
  );

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, ores_r.port, ores_r.ip, ores_r.id_low, ores_r.id_high, ostat_r};

  logic eligible;
  assign eligible = cur.verified && (cur.ctype <= maxt_r) && !taken_r[idx];

  // output register loads when it is free or being emptied this cycle
  assign ov_set = (!ovalid_r || out_acc) &&
                  ((state_r == S_OUT) ||
                   (state_r == S_PICK && (have_r || given_r == '0)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      limit_r  <= kbct_pkg::SUBNET_LIMIT_RESET;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == kbct_pkg::REG_SUBNET_LIMIT)
        limit_r <= cfg_pwdata[3:0];
      if (ov_set) ovalid_r <= 1'b1;
      else if (out_acc) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc && in_tdata[1:0] != kbct_pkg::OP_RSVD) begin
            op_r   <= in_tdata[1:0];
            in_c_r.id_high  <= in_tdata[65:2];
            in_c_r.id_low   <= in_tdata[129:66];
            in_c_r.ip       <= in_tdata[161:130];
            in_c_r.port     <= in_tdata[177:162];
            in_c_r.ctype    <= in_tdata[180:178];
            in_c_r.verified <= in_tdata[181];
            in_c_r.version  <= in_tdata[189:182];
            lan_r   <= in_tdata[190];
            gok_r   <= in_tdata[191];
            maxt_r  <= in_tdata[194:192];
            want_r  <= (in_tdata[198:195] > 4'(kbct_pkg::MAX_OUT)) ?
                       4'(kbct_pkg::MAX_OUT) : in_tdata[198:195];
            idx_r   <= '0;
            found_r <= 1'b0;
            same_r  <= '0;
            ecnt_r  <= '0;
            given_r <= '0;
            taken_r <= '0;
            have_r  <= 1'b0;
            state_r <= (in_tdata[1:0] == kbct_pkg::OP_CLOSEST) ? S_SEL : S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r < count_r) begin
            if (cur.id_high == in_c_r.id_high && cur.id_low == in_c_r.id_low) begin
              found_r <= 1'b1;
              fidx_r  <= idx;
            end
            if ((cur.ip & kbct_pkg::SUBNET_MASK) == (in_c_r.ip & kbct_pkg::SUBNET_MASK))
              same_r <= same_r + 1'b1;
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          ores_r  <= '0;
          olast_r <= 1'b1;
          state_r <= S_OUT;
          if (op_r == kbct_pkg::OP_ADD) begin
            if (found_r) ostat_r <= kbct_pkg::ST_DUP;
            else if (!gok_r) ostat_r <= kbct_pkg::ST_GLOBAL;
            else if ({{(32-CW){1'b0}}, same_r} >= {28'd0, limit_r} && !lan_r)
              ostat_r <= kbct_pkg::ST_SUBNET;
            else if (count_r >= CW'(BUCKET_SIZE)) ostat_r <= kbct_pkg::ST_FULL;
            else begin
              ostat_r <= kbct_pkg::ST_OK;
              mem_r[count_r[IW-1:0]] <= in_c_r;
              count_r <= count_r + 1'b1;
            end
          end else if (!found_r) begin
            ostat_r <= kbct_pkg::ST_NOTFOUND;
          end else begin
            ostat_r <= kbct_pkg::ST_OK;
            hold_r  <= mem_r[fidx_r];
            idx_r   <= CW'(fidx_r);
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // one slot moves down per cycle, the touched entry lands on top
          if (idx_r + 1'b1 < count_r) begin
            mem_r[idx] <= mem_r[IW'(idx_r + 1'b1)];
            idx_r <= idx_r + 1'b1;
          end else begin
            mem_r[idx] <= hold_r;
            state_r <= S_OUT;
          end
        end
        S_SEL: begin
          if (given_r >= want_r) begin
            state_r <= S_PICK;
          end else if (idx_r < count_r) begin
            if (eligible) begin
              ecnt_r <= ecnt_r + 1'b1;
              if (!have_r || cless) begin
                have_r  <= 1'b1;
                best_r  <= idx;
                bdist_r <= cdist;
              end
            end
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (!ovalid_r || out_acc) begin
            if (have_r) begin
              ostat_r  <= kbct_pkg::ST_OK;
              ores_r   <= mem_r[best_r];
              taken_r[best_r] <= 1'b1;
              given_r  <= given_r + 1'b1;
              have_r   <= 1'b0;
              idx_r    <= '0;
              ecnt_r   <= '0;
              // last when the request is met or no other eligible entry is left
              if (given_r + 1'b1 == want_r || ecnt_r == CW'(1)) begin
                olast_r <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                olast_r <= 1'b0;
                state_r <= S_SEL;
              end
            end else if (given_r == '0) begin
              ostat_r  <= kbct_pkg::ST_NORESULT;
              ores_r   <= '0;
              olast_r  <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_acc)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BUCKET_SIZE)) else $error("entry count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("count moved by other than one");
`endif
endmodule
